[design/lsdw_pkg.sv]
// Shared types and constants for the display shadow diff writer.
package lsdw_pkg;

    localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
    localparam logic [7:0] ROW1_OFFSET   = 8'h40;
    localparam logic [7:0] NIBBLE_MASK   = 8'h0F;
    localparam logic [7:0] BIT_EN        = 8'h04;
    localparam logic [7:0] BIT_BACKLIGHT = 8'h08;
    localparam logic [7:0] BIT_RS        = 8'h01;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;

    localparam int CMD_FIFO_DEPTH = 2;

    typedef struct packed {
        logic       row;
        logic [3:0] column;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [7:0] expander_byte;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic       start;
        logic       row;
        logic [3:0] column;
        logic [7:0] char_code;
    } t_cmd;

endpackage

[design/lsdw_front.sv]
// Front end: shadow lookup, change detection and run tracking.
module lsdw_front import lsdw_pkg::*; #(
    parameter int COLUMNS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_item i_item,
    input  logic     i_push,
    output logic     o_full,
    output t_cmd     o_cmd,
    output logic     o_cmd_push,
    input  logic     i_cmd_full
);

    localparam int ENTRIES = 2 * COLUMNS;
    localparam int IDX_W   = $clog2(ENTRIES);

    logic [7:0]       r_mem [ENTRIES];
    logic [7:0]       r_mem_q;
    logic [ENTRIES-1:0] r_vld;
    logic             r_rd_vld;
    logic             r_byp;
    logic [7:0]       r_byp_code;

    logic             r_a_valid;
    t_in_item         r_a;
    logic             r_a_in_range;
    logic [IDX_W-1:0] r_a_idx;

    logic             r_run_open;
    logic             r_run_row;
    logic [3:0]       r_run_col;

    logic             in_range;
    logic [IDX_W-1:0] in_idx;
    logic             accept;
    logic [7:0]       shadow;
    logic             a_changed;
    logic             a_stall;
    logic             a_retire;
    logic             a_cont;

    assign in_range = 32'(i_item.column) < COLUMNS;
    assign in_idx   = in_range ?
        ((i_item.row ? IDX_W'(COLUMNS) : IDX_W'(0)) + IDX_W'(i_item.column)) : IDX_W'(0);
    assign accept   = i_push && !o_full;

    assign shadow    = r_byp ? r_byp_code : (r_rd_vld ? r_mem_q : CHAR_SPACE);
    assign a_changed = r_a_valid && r_a_in_range && (shadow != r_a.char_code);
    assign a_stall   = a_changed && i_cmd_full;
    assign a_retire  = r_a_valid && !a_stall;
    assign o_full    = a_stall;
    assign o_cmd_push = a_changed && !i_cmd_full;

    assign a_cont = r_run_open && (r_run_row == r_a.row) &&
                    (({1'b0, r_run_col} + 5'd1) == {1'b0, r_a.column});

    always_comb begin
        o_cmd.start     = !a_cont;
        o_cmd.row       = r_a.row;
        o_cmd.column    = r_a.column;
        o_cmd.char_code = r_a.char_code;
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_push) begin
            r_mem[r_a_idx] <= r_a.char_code;
        end
        if (accept) begin
            r_mem_q      <= r_mem[in_idx];
            r_byp_code   <= r_a.char_code;
            r_a          <= i_item;
            r_a_in_range <= in_range;
            r_a_idx      <= in_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_vld      <= '0;
            r_rd_vld   <= 1'b0;
            r_byp      <= 1'b0;
            r_run_open <= 1'b0;
            r_run_row  <= 1'b0;
            r_run_col  <= 4'd0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
                r_rd_vld  <= r_vld[in_idx];
                r_byp     <= o_cmd_push && (r_a_idx == in_idx);
            end else if (a_retire) begin
                r_a_valid <= 1'b0;
            end
            if (o_cmd_push) begin
                r_vld[r_a_idx] <= 1'b1;
            end
            if (a_retire) begin
                r_run_open <= a_changed;
                r_run_row  <= r_a.row;
                r_run_col  <= r_a.column;
            end
        end
    end

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_a_valid)
        else $error("accepted item did not reach the lookup stage");

    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> (r_a_valid && i_cmd_full && r_a_in_range))
        else $error("input held off without a queued change");

endmodule

[design/lsdw_fifo.sv]
// Short command queue between the front end and the byte sequencer.
module lsdw_fifo import lsdw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    t_cmd             r_buf [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(CMD_FIFO_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_buf[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CMD_FIFO_DEPTH))
        else $error("command queue count out of range");

endmodule

[design/lsdw_back.sv]
// Back end: expands queued commands into expander bytes.
module lsdw_back import lsdw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_empty,
    output logic      o_cmd_pop,
    input  logic      i_backlight,
    output t_out_item o_result,
    output logic      o_res_empty,
    input  logic      i_res_pop
);

    logic [2:0] r_cnt;
    logic       r_out_valid;
    t_out_item  r_out;

    logic [2:0] step;
    logic [7:0] addr_byte;
    logic [7:0] src_byte;
    logic [3:0] nib;
    logic [7:0] n_byte;
    logic       step_last;
    logic       res_ready;
    logic       emit;

    assign step      = i_cmd.start ? r_cnt : {1'b1, r_cnt[1:0]};
    assign addr_byte = CMD_SET_ADDR |
        ((8'(i_cmd.column) + (i_cmd.row ? ROW1_OFFSET : 8'h00)) & 8'h7F);
    assign src_byte  = step[2] ? i_cmd.char_code : addr_byte;
    assign nib       = step[1] ? src_byte[3:0] : src_byte[7:4];
    assign n_byte    = ({4'h0, nib} & NIBBLE_MASK) << 4
                     | (i_backlight ? BIT_BACKLIGHT : 8'h00)
                     | (step[0]     ? 8'h00 : BIT_EN)
                     | (step[2]     ? BIT_RS : 8'h00);
    assign step_last = step == 3'd7;

    assign res_ready   = !r_out_valid || i_res_pop;
    assign emit        = !i_cmd_empty && res_ready;
    assign o_cmd_pop   = emit && step_last;
    assign o_result    = r_out;
    assign o_res_empty = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.expander_byte <= n_byte;
            r_out.last          <= step_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                r_cnt       <= step_last ? 3'd0 : r_cnt + 3'd1;
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_cnt_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 3'd0) |-> !i_cmd_empty)
        else $error("byte sequence in progress without a queued command");

    a_cont_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd_empty && !i_cmd.start) |-> !r_cnt[2])
        else $error("run continuation sequenced past its data byte");

    a_pop_flags_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (!o_res_empty && o_result.last))
        else $error("finished command without a flagged final byte");

endmodule

[design/lcd_shadow_diff_writer_top.sv]
// Top level of the two-row character display shadow diff writer.
// Each item names a target character by row, column and code. An item whose code
// matches the shadow, or whose column is at or beyond COLUMNS, gives no output. A changed
// character gives 4 expander bytes when it continues a run (same row, next column) and
// 8 when it starts one, the last byte flagged. The byte sequencer sends one byte per
// cycle while its output register is empty or being popped. The first byte of an item
// passes the lookup stage register, the command queue and the sequencer's output
// register on its way to the result ports. A two-entry command queue lets the lookup
// run ahead of the sequencer. The shadow reads as spaces after reset with no clearing
// pass.
module lcd_shadow_diff_writer_top import lsdw_pkg::*; #(
    parameter int COLUMNS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  logic      push,
    output logic      full,
    output t_out_item o_result,
    output logic      empty,
    input  logic      pop,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);

    logic r_backlight;
    t_cmd front_cmd;
    logic front_cmd_push;
    logic fifo_full;
    t_cmd head_cmd;
    logic fifo_empty;
    logic fifo_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlight <= 1'b1;
        end else if (i_cfg_we) begin
            r_backlight <= i_cfg_wdata;
        end
    end

    lsdw_front #(
        .COLUMNS(COLUMNS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_push     (push),
        .o_full     (full),
        .o_cmd      (front_cmd),
        .o_cmd_push (front_cmd_push),
        .i_cmd_full (fifo_full)
    );

    lsdw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_cmd_push),
        .i_data  (front_cmd),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_data  (head_cmd),
        .o_empty (fifo_empty)
    );

    lsdw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_empty (fifo_empty),
        .o_cmd_pop   (fifo_pop),
        .i_backlight (r_backlight),
        .o_result    (o_result),
        .o_res_empty (empty),
        .i_res_pop   (pop)
    );

endmodule

[tb/lcd_shadow_diff_writer_top_tb.sv]
// Self-checking testbench for the display shadow diff writer top level.
module lcd_shadow_diff_writer_top_tb;
    import lsdw_pkg::*;

    localparam int COLS       = 16;
    localparam int SETTLE_CYC = 16;

    class ShadowScoreboard;
        logic [7:0] shadow [0:2*COLS-1];
        bit         run_open;
        bit         run_row;
        bit [3:0]   run_col;
        bit         backlight;
        t_out_item  expected_bytes[$];
        int         errors;

        function new();
            foreach (shadow[i]) shadow[i] = CHAR_SPACE;
            run_open  = 1'b0;
            run_row   = 1'b0;
            run_col   = 4'd0;
            backlight = 1'b1;
            errors    = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        task report(input string msg);
            $display("mismatch @%0t: %s", $time, msg);
            errors++;
        endtask

        function void emit_nibble(logic [3:0] nib, logic rs, logic last_flag);
            t_out_item b;
            logic [7:0] base;
            base = {nib, 4'b0000} | (rs ? BIT_RS : 8'h00)
                 | (backlight ? BIT_BACKLIGHT : 8'h00);
            b.expander_byte = base | BIT_EN;
            b.last          = 1'b0;
            expected_bytes.push_back(b);
            b.expander_byte = base;
            b.last          = last_flag;
            expected_bytes.push_back(b);
        endfunction

        function void emit_byte(logic [7:0] value, logic rs, logic last_flag);
            emit_nibble(value[7:4], rs, 1'b0);
            emit_nibble(value[3:0], rs, last_flag);
        endfunction

        function void note_item(t_in_item it);
            logic [4:0] idx;
            logic [7:0] addr;
            bit         cont;
            idx = {it.row, it.column};
            if (shadow[idx] == it.char_code) begin
                run_open = 1'b0;
            end else begin
                cont = run_open && (run_row == it.row) &&
                       ({1'b0, run_col} + 5'd1 == {1'b0, it.column});
                if (!cont) begin
                    addr = CMD_SET_ADDR |
                        (({4'b0, it.column} + (it.row ? ROW1_OFFSET : 8'h00)) & 8'h7F);
                    emit_byte(addr, 1'b0, 1'b0);
                end
                emit_byte(it.char_code, 1'b1, 1'b1);
                shadow[idx] = it.char_code;
                run_open    = 1'b1;
                run_row     = it.row;
                run_col     = it.column;
            end
        endfunction

        task check_result(input t_out_item got);
            t_out_item want;
            if (expected_bytes.size() == 0) begin
                report($sformatf("unexpected transfer byte=%02h last=%0b",
                                 got.expander_byte, got.last));
            end else begin
                want = expected_bytes.pop_front();
                if (got.expander_byte !== want.expander_byte)
                    report($sformatf("expander_byte got %02h want %02h",
                                     got.expander_byte, want.expander_byte));
                if (got.last !== want.last)
                    report($sformatf("last got %0b want %0b (byte %02h)",
                                     got.last, want.last, want.expander_byte));
            end
        endtask
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    t_in_item  i_item      = '0;
    logic      push        = 1'b0;
    logic      full;
    t_out_item o_result;
    logic      empty;
    logic      pop         = 1'b0;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_wdata = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    ShadowScoreboard sb = new();

    lcd_shadow_diff_writer_top #(
        .COLUMNS (COLS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .push        (push),
        .full        (full),
        .o_result    (o_result),
        .empty       (empty),
        .pop         (pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_result(o_result);
        pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic t_in_item make_item(logic row, logic [3:0] col, logic [7:0] code);
        t_in_item it;
        it.row       = row;
        it.column    = col;
        it.char_code = code;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_item(it);
    endtask

    task automatic write_backlight(input logic value);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        sb.backlight = value;
    endtask

    task automatic send_random(input int count);
        int         sent;
        int         col;
        int         len;
        logic       row;
        logic [7:0] code;
        t_in_item   it;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 20) begin
                it = make_item(1'($urandom_range(1)), 4'($urandom_range(15)),
                               8'($urandom_range(255)));
                if (it.char_code != sb.shadow[{it.row, it.column}]) sent++;
                send_item(it);
            end else begin
                row = 1'($urandom_range(1));
                col = $urandom_range(15);
                len = $urandom_range(1, 6);
                while (len > 0 && col < COLS) begin
                    if ($urandom_range(99) < 10) begin
                        code = sb.shadow[{row, col[3:0]}];
                    end else begin
                        code = 8'($urandom_range(255));
                        if (code == sb.shadow[{row, col[3:0]}]) code = ~code;
                        sent++;
                    end
                    send_item(make_item(row, col[3:0], code));
                    col++;
                    len--;
                end
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(make_item(1'b0, 4'd0,  8'h20));
        send_item(make_item(1'b0, 4'd0,  8'h00));
        send_item(make_item(1'b0, 4'd1,  8'hFF));
        send_item(make_item(1'b0, 4'd2,  8'h20));
        send_item(make_item(1'b0, 4'd3,  8'h41));
        send_item(make_item(1'b0, 4'd15, 8'h7E));
        send_item(make_item(1'b1, 4'd0,  8'h5A));
        send_item(make_item(1'b1, 4'd1,  8'hA5));
        send_item(make_item(1'b0, 4'd2,  8'h33));
        send_item(make_item(1'b1, 4'd15, 8'hFF));
        send_item(make_item(1'b1, 4'd15, 8'hFF));
        send_item(make_item(1'b1, 4'd14, 8'h11));
        send_item(make_item(1'b1, 4'd15, 8'h22));
        send_item(make_item(1'b1, 4'd0,  8'h96));
        send_item(make_item(1'b1, 4'd1,  8'h69));
        send_item(make_item(1'b1, 4'd2,  8'hC3));

        for (int phase = 0; phase < 4; phase++) begin
            write_backlight(phase[0]);
            case (phase)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 56; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 56; end
                default: begin send_idle_pct = 21; recv_idle_pct = 21; end
            endcase
            send_random(37);
        end

        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("lcd_shadow_diff_writer_top_tb: PASS");
        else
            $display("lcd_shadow_diff_writer_top_tb: FAIL");
        $finish;
    end

    initial begin
        #400000;
        $display("lcd_shadow_diff_writer_top_tb: FAIL");
        $finish;
    end

endmodule
